// File: hw/rtl/sha512_hash_engine_defines.svh
// Assertion macros for the hash engine
`ifndef SHA512_HASH_ENGINE_DEFINES_SVH
`define SHA512_HASH_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/sha512_pkg.sv
`default_nettype none
package sha512_pkg;

  localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;
  localparam logic [60:0] BYTES_MAX = 61'h1FFF_FFFF_FFFF_FFFF;

  typedef logic [63:0] word_t;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a request
    ST_COMP,    // compression running
    ST_PAD,     // inserting padding / length words
    ST_OUT      // presenting digest words
  } state_t;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [6:0] i);
    word_t r;
    case (i)
      7'd0: r = 64'h428a2f98d728ae22; 7'd1: r = 64'h7137449123ef65cd;
      7'd2: r = 64'hb5c0fbcfec4d3b2f; 7'd3: r = 64'he9b5dba58189dbbc;
      7'd4: r = 64'h3956c25bf348b538; 7'd5: r = 64'h59f111f1b605d019;
      7'd6: r = 64'h923f82a4af194f9b; 7'd7: r = 64'hab1c5ed5da6d8118;
      7'd8: r = 64'hd807aa98a3030242; 7'd9: r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec; default: r = 64'h6c44198c4a475817;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sha512_core.sv
`default_nettype none
// Iterative compression: one round per cycle over a 16-word schedule ring,
// then feed-forward of the eight working words into the chaining words.
`include "sha512_hash_engine_defines.svh"
module sha512_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,     // block complete on block_in
  input  wire logic                 reinit,    // restore initial chaining words
  input  wire sha512_pkg::word_t    block_in [16],
  input  wire logic [2:0]           hsel,
  output sha512_pkg::word_t         hword,
  output logic                      busy
);

  sha512_pkg::word_t w [16];
  sha512_pkg::word_t v [8];
  sha512_pkg::word_t h [8];
  logic [6:0] round_index;
  logic [3:0] ff_index;
  logic       run;
  logic       ffd;

  sha512_pkg::word_t w15, w2, s0, s1, wt, big0, big1, ch, maj, t1, t2;
  logic [3:0] t;

  function automatic sha512_pkg::word_t rotr(input sha512_pkg::word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  assign t = round_index[3:0];

  // Schedule expansion and round function
  always_comb begin
    w15  = w[t + 4'd1];
    w2   = w[t + 4'd14];
    s0   = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
    s1   = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
    wt   = (round_index >= 7'd16) ? (w[t] + s0 + w[t + 4'd9] + s1) : w[t];
    big1 = rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41);
    ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1   = v[7] + big1 + ch + sha512_pkg::round_k(round_index) + wt;
    big0 = rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39);
    maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2   = big0 + maj;
  end

  // Sequencer: rounds, then feed-forward one word a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      ffd <= 1'b0;
      round_index <= '0;
      ff_index <= '0;
      for (int i = 0; i < 8; i++) h[i] <= sha512_pkg::init_hash(3'(i));
    end else begin
      if (reinit) begin
        for (int i = 0; i < 8; i++) h[i] <= sha512_pkg::init_hash(3'(i));
      end
      if (start) begin
        run <= 1'b1;
        round_index <= '0;
        for (int i = 0; i < 16; i++) w[i] <= block_in[i];
        for (int i = 0; i < 8; i++) v[i] <= h[i];
      end else if (run) begin
        w[t] <= wt;
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        if (round_index == 7'd79) begin
          run <= 1'b0;
          ffd <= 1'b1;
          ff_index <= '0;
          round_index <= '0;
        end else begin
          round_index <= round_index + 7'd1;
        end
      end else if (ffd) begin
        h[ff_index[2:0]] <= h[ff_index[2:0]] + v[ff_index[2:0]];
        if (ff_index == 4'd7) ffd <= 1'b0;
        ff_index <= ff_index + 4'd1;
      end
    end
  end

  assign busy  = run | ffd;
  assign hword = h[hsel];

  `SHA_ASSERT_IMPL(a_no_start_busy, clk, rst, start, !busy)
  `SHA_ASSERT_IMPL(a_round_range, clk, rst, run, round_index <= 7'd79)
  `SHA_ASSERT_NEXT(a_ff_follows, clk, rst, run && round_index == 7'd79, ffd && !run)
  `SHA_ASSERT_IMPL(a_excl, clk, rst, 1'b1, !(run && ffd))

endmodule
`default_nettype wire

// File: hw/rtl/sha512_hash_engine.sv
`default_nettype none
// Channel  Dir  tdata                            tuser         tlast
// s_axis   in   [63:0] data_word                 [3:0] byte_count  last_word
// m_axis   out  [63:0] digest_word               -             digest_last
// Each whole block runs through the rounds and the feed-forward in the
// shared round unit; s_axis_tready is low meanwhile.
// A last word is followed by padding that fills out its block and at most one
// more, then 8 digest words, one per accepted m_axis request; output stalls hold the engine.
// Synchronous active-high reset restores the initial chaining words.
`include "sha512_hash_engine_defines.svh"
module sha512_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // data_word
  input  wire logic [3:0]  s_axis_tuser,   // byte_count
  input  wire logic        s_axis_tlast,   // last_word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // digest_word
  output logic             m_axis_tlast    // digest_last
);

  sha512_pkg::state_t state, state_next;
  sha512_pkg::word_t  block_words [16];
  sha512_pkg::word_t  block_view [16];
  logic [60:0] message_bytes;
  logic [3:0]  word_slot;
  logic [2:0]  out_index;
  logic        pad_phase;    // 0: marker word pending, 1: zeros/length
  logic        spill;        // marker took word 14, length goes to the next block
  logic        marker_put;
  logic        busy, start, reinit, acc, put, out_acc;
  sha512_pkg::word_t put_val, marked, hword;
  logic [3:0]  n;
  logic [60:0] msg_new;

  assign acc     = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;
  assign n = (s_axis_tuser > 4'd8) ? 4'd8 : s_axis_tuser;

  // Saturating byte counter
  always_comb begin
    logic [3:0] add;
    add = s_axis_tlast ? n : 4'd8;
    msg_new = (message_bytes >= sha512_pkg::BYTES_MAX - 61'(add))
              ? sha512_pkg::BYTES_MAX : message_bytes + 61'(add);
  end

  // Data word with marker byte appended after the valid bytes
  always_comb begin
    logic [63:0] keep;
    keep = ~(64'hFFFF_FFFF_FFFF_FFFF >> (7'd8 * 7'(n)));
    marked = (s_axis_tdata & keep) | (sha512_pkg::PAD_WORD >> (7'd8 * 7'(n)));
  end

  // Word to store this cycle
  always_comb begin
    put = 1'b0;
    put_val = '0;
    if (state == sha512_pkg::ST_IDLE && acc) begin
      put = 1'b1;
      put_val = (s_axis_tlast && n != 4'd8) ? marked : s_axis_tdata;
    end else if (state == sha512_pkg::ST_PAD && !busy) begin
      put = 1'b1;
      if (!pad_phase) put_val = sha512_pkg::PAD_WORD;
      else if (word_slot == 4'd15 && !spill) put_val = {message_bytes, 3'b000};
      else put_val = '0;
    end
  end

  // Marker byte lands in the block this cycle
  assign marker_put = put && ((state == sha512_pkg::ST_IDLE && s_axis_tlast && n != 4'd8) ||
                              (state == sha512_pkg::ST_PAD && !pad_phase));

  assign start  = put && word_slot == 4'd15;
  assign reinit = out_acc && m_axis_tlast;

  // Block seen by the core: the word stored this cycle completes it
  always_comb begin
    for (int i = 0; i < 16; i++) block_view[i] = block_words[i];
    block_view[15] = put_val;
  end

  sha512_core u_core (
    .clk(clk), .rst(rst), .start(start), .reinit(reinit),
    .block_in(block_view), .hsel(out_index), .hword(hword), .busy(busy)
  );

  // Block buffer: current put lands in the array; full block passes through
  always_ff @(posedge clk) begin
    if (put) block_words[word_slot] <= put_val;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= sha512_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_bytes <= '0;
      word_slot <= '0;
      out_index <= '0;
      pad_phase <= 1'b0;
      spill <= 1'b0;
    end else begin
      if (acc) begin
        message_bytes <= msg_new;
        pad_phase <= !(s_axis_tlast && n == 4'd8);
      end
      if (put) word_slot <= word_slot + 4'd1;
      if (state == sha512_pkg::ST_PAD && put) pad_phase <= 1'b1;
      if (marker_put && word_slot == 4'd14) spill <= 1'b1;
      else if (start) spill <= 1'b0;
      if (out_acc) begin
        out_index <= out_index + 3'd1;
        if (m_axis_tlast) begin
          message_bytes <= '0;
          word_slot <= '0;
        end
      end
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state)
      sha512_pkg::ST_IDLE: begin
        s_axis_tready = !busy;
        if (acc && s_axis_tlast) state_next = sha512_pkg::ST_PAD;
      end
      sha512_pkg::ST_PAD: begin
        if (put && pad_phase && !spill && word_slot == 4'd15)
          state_next = sha512_pkg::ST_COMP;
      end
      sha512_pkg::ST_COMP: begin
        if (!busy && !start) state_next = sha512_pkg::ST_OUT;
      end
      sha512_pkg::ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (out_acc && m_axis_tlast) state_next = sha512_pkg::ST_IDLE;
      end
      default: state_next = sha512_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tdata = hword;
  assign m_axis_tlast = (out_index == 3'd7);

  `SHA_ASSERT_IMPL(a_out_idle_core, clk, rst, m_axis_tvalid, !busy)
  `SHA_ASSERT_IMPL(a_no_in_busy, clk, rst, s_axis_tready, !busy)
  `SHA_ASSERT_NEXT(a_last_clears, clk, rst, out_acc && m_axis_tlast, word_slot == 4'd0)

endmodule
`default_nettype wire
